// ===== src/atfb_pkg.sv =====
// atfb_pkg: shared types, character codes and helpers for the telemetry frame builder
// no dependencies; imported by every module of the block

package atfb_pkg;

  localparam logic [7:0] ASCII_AT   = 8'h40;
  localparam logic [7:0] ASCII_R    = 8'h52;
  localparam logic [7:0] ASCII_A    = 8'h41;
  localparam logic [7:0] ASCII_X    = 8'h58;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_CR   = 8'h0D;
  localparam logic [3:0] NIB_MASK   = 4'hF;

  localparam int unsigned NUM_BUTTONS = 4;

  // fixed part of the checksum: '@' 'R' 'A' 'B' 'C' 'D' and the '0' of each button digit
  localparam logic [7:0] CHK_BASE = 8'(int'(ASCII_AT) + int'(ASCII_R)
                                     + 4 * int'(ASCII_A) + 6
                                     + 4 * int'(ASCII_ZERO));

  typedef struct packed {
    logic [9:0] light_reading;
    logic       button_a_level;
    logic       button_b_level;
    logic       button_c_state;
    logic       button_d_state;
  } atfb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } atfb_out_t;

  // partially converted sample inside the front pipeline
  typedef struct packed {
    logic       thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [9:0] rem;
    logic [3:0] levels;
  } atfb_work_t;

  // classified sample passed from front to back
  typedef struct packed {
    logic [3:0][3:0] digits;
    logic [1:0]      ndig_m1;
    logic [3:0]      levels;
    logic [7:0]      chk;
  } atfb_desc_t;

  typedef enum logic [3:0] {
    ST_AT,
    ST_R,
    ST_DIG,
    ST_BTN_L,
    ST_BTN_V,
    ST_X,
    ST_HI,
    ST_LO,
    ST_CR
  } atfb_state_e;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ASCII_ZERO + {4'd0, nib};
    end else begin
      c = ASCII_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== src/atfb_front.sv =====
// atfb_front: three-stage intake pipeline that splits the reading into decimal digits
// and works out digit count and checksum; depends on atfb_pkg

module atfb_front
  import atfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  atfb_in_t   in_data_i,
  output logic       desc_valid_o,
  input  logic       desc_ready_i,
  output atfb_desc_t desc_o
);

  logic       v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic       en1, en2, en3;
  atfb_work_t s1_q, s1_d, s2_q, s2_d, s3_q, s3_d;

  logic [9:0]  r1;
  logic [15:0] prod1;
  logic [6:0]  r2;
  logic [14:0] prod2;
  logic [6:0]  r3;
  logic [3:0]  ones;
  logic [1:0]  ndig_m1;
  logic [2:0]  ndig;
  logic [7:0]  dsum;

  assign en3 = !v3_q || desc_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign v1_d = en1 ? in_valid_i : v1_q;
  assign v2_d = en2 ? v1_q : v2_q;
  assign v3_d = en3 ? v2_q : v3_q;

  // stage 1: thousands and hundreds
  always_comb begin
    s1_d        = s1_q;
    s1_d.thou   = (in_data_i.light_reading >= 10'd1000);
    r1          = s1_d.thou ? (in_data_i.light_reading - 10'd1000) : in_data_i.light_reading;
    prod1       = 16'(r1) * 16'd41;
    s1_d.hund   = prod1[15:12];
    s1_d.tens   = 4'd0;
    s1_d.rem    = r1;
    s1_d.levels = {in_data_i.button_d_state, in_data_i.button_c_state,
                   in_data_i.button_b_level, in_data_i.button_a_level};
  end

  // stage 2: remainder below one hundred
  always_comb begin
    s2_d     = s1_q;
    r2       = 7'(s1_q.rem - 10'(s1_q.hund) * 10'd100);
    s2_d.rem = {3'd0, r2};
  end

  // stage 3: tens
  always_comb begin
    s3_d      = s2_q;
    prod2     = 15'(s2_q.rem[6:0]) * 15'd205;
    s3_d.tens = prod2[14:11];
  end

  // classification out of stage 3
  always_comb begin
    r3   = s3_q.rem[6:0];
    ones = 4'(r3 - 7'(s3_q.tens) * 7'd10);
    if (s3_q.thou) begin
      ndig_m1 = 2'd3;
    end else if (s3_q.hund != 4'd0) begin
      ndig_m1 = 2'd2;
    end else if (s3_q.tens != 4'd0) begin
      ndig_m1 = 2'd1;
    end else begin
      ndig_m1 = 2'd0;
    end
    ndig = {1'b0, ndig_m1} + 3'd1;
    dsum = {7'd0, s3_q.thou} + {4'd0, s3_q.hund} + {4'd0, s3_q.tens} + {4'd0, ones};
    desc_o.digits  = {{3'd0, s3_q.thou}, s3_q.hund, s3_q.tens, ones};
    desc_o.ndig_m1 = ndig_m1;
    desc_o.levels  = s3_q.levels;
    desc_o.chk     = CHK_BASE + 8'({5'd0, ndig} * ASCII_ZERO) + dsum
                     + {7'd0, s3_q.levels[0]} + {7'd0, s3_q.levels[1]}
                     + {7'd0, s3_q.levels[2]} + {7'd0, s3_q.levels[3]};
  end

  assign desc_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (en2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (en3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

endmodule

// ===== src/atfb_queue.sv =====
// atfb_queue: two-entry queue of classified samples between front and back
// depends on atfb_pkg

module atfb_queue
  import atfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  atfb_desc_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output atfb_desc_t pop_data_o
);

  atfb_desc_t  mem_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/atfb_back.sv =====
// atfb_back: frame sequencer that emits one character per beat into an output register
// depends on atfb_pkg

module atfb_back
  import atfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       desc_valid_i,
  output logic       desc_ready_o,
  input  atfb_desc_t desc_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output atfb_out_t  out_data_o
);

  atfb_state_e state_q, state_d;
  logic [1:0]  dig_q, dig_d;
  logic [1:0]  btn_q, btn_d;
  logic        out_valid_q, out_valid_d;
  atfb_out_t   out_q, out_d;
  logic        load;

  assign load = desc_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    dig_d         = dig_q;
    btn_d         = btn_q;
    out_d.frame_byte = ASCII_AT;
    out_d.frame_end  = 1'b0;
    desc_ready_o  = 1'b0;
    case (state_q)
      ST_AT: begin
        out_d.frame_byte = ASCII_AT;
        state_d = ST_R;
      end
      ST_R: begin
        out_d.frame_byte = ASCII_R;
        dig_d   = desc_i.ndig_m1;
        state_d = ST_DIG;
      end
      ST_DIG: begin
        out_d.frame_byte = ASCII_ZERO + {4'd0, desc_i.digits[dig_q]};
        if (dig_q == 2'd0) begin
          btn_d   = 2'd0;
          state_d = ST_BTN_L;
        end else begin
          dig_d = dig_q - 2'd1;
        end
      end
      ST_BTN_L: begin
        out_d.frame_byte = ASCII_A + {6'd0, btn_q};
        state_d = ST_BTN_V;
      end
      ST_BTN_V: begin
        out_d.frame_byte = ASCII_ZERO + {7'd0, desc_i.levels[btn_q]};
        if (btn_q == 2'(NUM_BUTTONS - 1)) begin
          state_d = ST_X;
        end else begin
          btn_d   = btn_q + 2'd1;
          state_d = ST_BTN_L;
        end
      end
      ST_X: begin
        out_d.frame_byte = ASCII_X;
        state_d = ST_HI;
      end
      ST_HI: begin
        out_d.frame_byte = hex_char(desc_i.chk[7:4]);
        state_d = ST_LO;
      end
      ST_LO: begin
        out_d.frame_byte = hex_char(desc_i.chk[3:0] & NIB_MASK);
        state_d = ST_CR;
      end
      ST_CR: begin
        out_d.frame_byte = ASCII_CR;
        out_d.frame_end  = 1'b1;
        desc_ready_o     = load;
        state_d = ST_AT;
      end
      default: begin
        state_d = ST_AT;
      end
    endcase
    if (!load) begin
      state_d = state_q;
      dig_d   = dig_q;
      btn_d   = btn_q;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_AT;
      dig_q       <= 2'd0;
      btn_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dig_q       <= dig_d;
      btn_q       <= btn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/ascii_telemetry_frame_builder.sv =====
// ascii_telemetry_frame_builder: top level joining intake pipeline, queue and frame sequencer
// depends on atfb_pkg, atfb_front, atfb_queue and atfb_back

// Each accepted sample set becomes one ASCII frame of 15 to 18 bytes, one beat per cycle
// while the receiver is ready: '@' 'R', the light reading in decimal, 'A'..'D' each with
// its digit, 'X', two uppercase hex checksum digits and a closing carriage return flagged
// with frame_end. The first byte passes through the three-stage digit pipeline, the queue
// write and the output register. Up to two classified samples wait in the queue and three
// more in the pipeline, so intake keeps going while the output side stalls, until these
// are full. No state across frames.

module ascii_telemetry_frame_builder
  import atfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  atfb_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output atfb_out_t out_data_o
);

  logic       f_valid, f_ready, b_valid, b_ready;
  atfb_desc_t f_desc, b_desc;

  atfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .desc_valid_o (f_valid),
    .desc_ready_i (f_ready),
    .desc_o       (f_desc)
  );

  atfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_desc),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_desc)
  );

  atfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (b_valid),
    .desc_ready_o (b_ready),
    .desc_i       (b_desc),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  a_end_is_cr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.frame_byte == ASCII_CR)
    else $error("frame_end on a byte other than carriage return");

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.frame_end
    |=> !out_valid_o || out_data_o.frame_byte == ASCII_AT)
    else $error("frame does not start with '@' after carriage return");

  a_at_then_r : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.frame_byte == ASCII_AT
    |=> !out_valid_o || out_data_o.frame_byte == ASCII_R)
    else $error("'@' not followed by 'R'");

  a_dequeue_on_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_ready |=> out_valid_o && out_data_o.frame_end)
    else $error("sample released without carriage return loaded");

endmodule

// ===== tb/tb_ascii_telemetry_frame_builder.sv =====
// tb_ascii_telemetry_frame_builder: self-checking testbench for the telemetry frame builder
// predicts every frame byte from the accepted sample set and checks each output beat in order
// depends on atfb_pkg and ascii_telemetry_frame_builder

module tb_ascii_telemetry_frame_builder;
  import atfb_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  atfb_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  atfb_out_t out_data;

  atfb_out_t frame_bytes_q[$];
  int        error_count = 0;
  int        quiet_cycles = 0;
  int        rx_hold_req = 0;
  int        rx_stall_left = 0;
  bit        tx_idle_on = 1'b0;
  bit        rx_idle_on = 1'b0;

  ascii_telemetry_frame_builder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap(int pct);
    int p;
    p = $urandom_range(0, 99);
    if (p >= pct) return 0;
    p = $urandom_range(0, 99);
    if (p < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] nibble_char(logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = ASCII_ZERO + {4'd0, n};
    end else begin
      c = ASCII_A + {4'd0, n} - 8'd10;
    end
    return c;
  endfunction

  // expected frame bytes for one sample set
  function automatic void build_frame(atfb_in_t s);
    logic [7:0] chars[$];
    logic [7:0] sum;
    logic [3:0] dec[4];
    logic [3:0] btn;
    int         nd;
    int         r;
    atfb_out_t  b;
    nd = 0;
    r = int'(s.light_reading);
    btn = {s.button_a_level, s.button_b_level, s.button_c_state, s.button_d_state};
    chars.push_back(ASCII_AT);
    chars.push_back(ASCII_R);
    do begin
      dec[nd] = 4'(r % 10);
      nd++;
      r = r / 10;
    end while (r != 0);
    for (int i = nd - 1; i >= 0; i--) chars.push_back(ASCII_ZERO + {4'd0, dec[i]});
    for (int i = 0; i < 4; i++) begin
      chars.push_back(ASCII_A + 8'(i));
      chars.push_back(ASCII_ZERO + {7'd0, btn[3 - i]});
    end
    sum = '0;
    foreach (chars[i]) sum = sum + chars[i];
    chars.push_back(ASCII_X);
    chars.push_back(nibble_char(sum[7:4]));
    chars.push_back(nibble_char(sum[3:0] & NIB_MASK));
    chars.push_back(ASCII_CR);
    foreach (chars[i]) begin
      b.frame_byte = chars[i];
      b.frame_end  = (i == chars.size() - 1);
      frame_bytes_q.push_back(b);
    end
  endfunction

  function automatic atfb_in_t random_sample();
    atfb_in_t s;
    int       v;
    case ($urandom_range(0, 9))
      0, 1:    v = $urandom_range(0, 9);
      2, 3:    v = $urandom_range(10, 99);
      4, 5:    v = $urandom_range(100, 999);
      6, 7:    v = $urandom_range(1000, 1023);
      default: v = $urandom_range(0, 1023);
    endcase
    s.light_reading = 10'(v);
    {s.button_a_level, s.button_b_level, s.button_c_state, s.button_d_state} = 4'($urandom);
    return s;
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  task automatic send_sample(atfb_in_t s);
    int gap;
    gap = tx_idle_on ? pick_gap(40) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    build_frame(s);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int         readings[16] = '{0, 1, 9, 10, 42, 99, 100, 505, 999, 1000, 1009, 1023,
                                 0, 1023, 7, 512};
    logic [3:0] levels[16]   = '{4'b0000, 4'b1111, 4'b1000, 4'b0100, 4'b0010, 4'b0001,
                                 4'b0101, 4'b1010, 4'b1111, 4'b0000, 4'b0110, 4'b1111,
                                 4'b1111, 4'b0000, 4'b1001, 4'b0011};
    atfb_in_t   s;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    foreach (readings[i]) begin
      s.light_reading = 10'(readings[i]);
      {s.button_a_level, s.button_b_level, s.button_c_state, s.button_d_state} = levels[i];
      send_sample(s);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(int n);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (n) send_sample(random_sample());
  endtask

  task automatic test_back_to_back(int n);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (n) send_sample(random_sample());
  endtask

  // receiver holds off while the sender keeps offering, so intake backs up
  task automatic test_output_hold();
    tx_idle_on = 1'b0;
    rx_hold_req = LONG_HOLD;
    repeat (15) send_sample(random_sample());
    rx_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (3) begin
      repeat (7) send_sample(random_sample());
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    int g;
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (rx_hold_req > 0) begin
      rx_stall_left = rx_hold_req - 1;
      rx_hold_req = 0;
      out_ready <= 1'b0;
    end else if (rx_idle_on) begin
      g = pick_gap(12);
      if (g > 0) rx_stall_left = g - 1;
      out_ready <= (g == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // output beat checker
  always @(posedge clk) begin
    atfb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_bytes_q.size() == 0) begin
        flag_error($sformatf("unexpected beat: byte %h end %b",
                             out_data.frame_byte, out_data.frame_end));
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_data.frame_byte !== want.frame_byte || out_data.frame_end !== want.frame_end) begin
          flag_error($sformatf("mismatch: byte exp %h got %h, end exp %b got %b",
                               want.frame_byte, out_data.frame_byte,
                               want.frame_end, out_data.frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles without a beat", quiet_cycles);
      $display("tb_ascii_telemetry_frame_builder: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_random_traffic(200);
    test_output_hold();
    test_back_to_back(30);
    test_drain_pause();
    test_random_traffic(180);
    wait_drained();
    repeat (40) @(posedge clk);
    if (frame_bytes_q.size() != 0) begin
      flag_error($sformatf("%0d frame bytes never arrived", frame_bytes_q.size()));
    end
    if (error_count == 0) begin
      $display("tb_ascii_telemetry_frame_builder: done, clean");
    end else begin
      $display("tb_ascii_telemetry_frame_builder: done, errors");
    end
    $finish;
  end

endmodule
